>>> hw/rtl/stq_pkg.sv
// Shared types and constants for the semaphore task-queue engine.
`default_nettype none

package stq_pkg;

    // Field widths of the channels
    localparam int ACT_W = 2;
    localparam int SEM_W = 4;
    localparam int ID_W  = 7;
    localparam int CNT_W = 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_P        = 2'd2;
    localparam logic [ACT_W-1:0] ACT_V        = 2'd3;

    // Count bounds and reset value
    localparam logic signed [CNT_W-1:0] CNT_MIN   = 8'sh80;
    localparam logic signed [CNT_W-1:0] CNT_MAX   = 8'sh7f;
    localparam logic signed [CNT_W-1:0] CNT_RESET = 8'sd1;

    localparam logic [ID_W-1:0] ID_NONE = '0;

    // One semaphore entry: signed count and wait queue head
    typedef struct packed {
        logic signed [CNT_W-1:0] count;
        logic [ID_W-1:0]         head;
    } sem_entry_t;

    // Write request to the semaphore store
    typedef struct packed {
        logic             we;
        logic [SEM_W-1:0] addr;
        sem_entry_t       data;
    } sem_wr_t;

    // Write request to the link store
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] addr;
        logic [ID_W-1:0] data;
    } link_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/stq_if.sv
// Request and response channel interfaces of the semaphore task-queue engine.
`default_nettype none

interface stq_req_if;
    import stq_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SEM_W-1:0] sem_index;
    logic [ID_W-1:0]  caller_task;

    modport source (output valid, action, sem_index, caller_task, input ready);
    modport sink   (input valid, action, sem_index, caller_task, output ready);
endinterface

interface stq_rsp_if;
    import stq_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] task_out;
    logic            blocked;
    logic            idle;
    logic            no_free_slot;

    modport source (output valid, task_out, blocked, idle, no_free_slot, input ready);
    modport sink   (input valid, task_out, blocked, idle, no_free_slot, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stq_sem_mem.sv
// Semaphore store: count and wait head per semaphore, registered read.
`default_nettype none

module stq_sem_mem #(
    parameter int NUM_SEMAPHORES = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire  [stq_pkg::SEM_W-1:0]  raddr,
    output stq_pkg::sem_entry_t        rdata,
    input  stq_pkg::sem_wr_t           wr
);
    import stq_pkg::*;

    localparam int AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

    sem_entry_t                mem [NUM_SEMAPHORES];
    logic [NUM_SEMAPHORES-1:0] vld_reg;
    sem_entry_t                rd_data_reg;
    logic                      rd_vld_reg;

    // Write the entry and register the read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[raddr[AW-1:0]];
    end

    // Mark written entries; unwritten ones read as the reset entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr[AW-1:0]];
        end
    end

    always_comb
    begin
        if (rd_vld_reg)
        begin
            rdata = rd_data_reg;
        end
        else
        begin
            rdata.count = CNT_RESET;
            rdata.head  = ID_NONE;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stq_link_mem.sv
// Link store: next pointer per task slot, registered read.
`default_nettype none

module stq_link_mem #(
    parameter int NUM_TASKS = 5
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire  [stq_pkg::ID_W-1:0]  raddr,
    output logic [stq_pkg::ID_W-1:0]  rdata,
    input  stq_pkg::link_wr_t         wr
);
    import stq_pkg::*;

    localparam int DEPTH = NUM_TASKS + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [ID_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [ID_W-1:0]  rd_data_reg;
    logic             rd_vld_reg;

    // Write the link and register the read
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[raddr[AW-1:0]];
    end

    // Mark written links; unwritten ones read as none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr[AW-1:0]];
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : ID_NONE;

endmodule

`default_nettype wire

>>> hw/rtl/semaphore_task_queue_engine_unit.sv
// Top level of the semaphore task-queue engine: action sequencer over two stores.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | action, sem_index, caller_task
//  rsp     | out | valid / ready | task_out, blocked, idle, no_free_slot
//
// One item at a time; a request is taken only in the idle state. Register appends a new
// slot to the ready queue, Start pops the ready queue, a blocking P appends the caller to
// the wait queue and then pops the ready queue, and a waking V pops the wait queue and
// appends that task to the ready queue. The tail walk of an append reads the link store
// once per cycle and reads at most NUM_TASKS links.
// Reset clears all queues, slots and counts at once through valid bits; no sweep.
// A result waiting in the output register lets the next item be accepted; the
// sequencer holds its final state only while that register is full and not being taken.
`default_nettype none

module semaphore_task_queue_engine_unit #(
    parameter int NUM_TASKS      = 5,
    parameter int NUM_SEMAPHORES = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp
);
    import stq_pkg::*;

    localparam int STEP_W = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;
    localparam int SLOT_W = $clog2(NUM_TASKS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_TASKS - 1);
    localparam logic [ID_W-1:0]   ID_MAX    = ID_W'(NUM_TASKS);
    localparam logic [SEM_W:0]    SEM_LIM   = (SEM_W + 1)'(NUM_SEMAPHORES);

    // Queue selectors
    localparam logic Q_READY = 1'b0;
    localparam logic Q_WAIT  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEM,
        S_A_START,
        S_A_WAIT,
        S_A_CLR,
        S_P_START,
        S_P_WAIT,
        S_NEXT,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [ACT_W-1:0]        act_reg, act_next;
    logic [SEM_W-1:0]        sem_reg, sem_next;
    logic [ID_W-1:0]         caller_reg, caller_next;
    logic                    target_reg, target_next;
    logic                    phase_reg, phase_next;
    logic                    touch_reg, touch_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [ID_W-1:0]         cur_reg, cur_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [ID_W-1:0]         pop_reg, pop_next;
    logic [ID_W-1:0]         rhead_reg, rhead_next;
    logic signed [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]         whead_reg, whead_next;
    logic [NUM_TASKS:1]      slot_used_reg, slot_used_next;
    logic [ID_W-1:0]         res_task_reg, res_task_next;
    logic                    res_blocked_reg, res_blocked_next;
    logic                    res_idle_reg, res_idle_next;
    logic                    res_nofree_reg, res_nofree_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ID_W-1:0]         out_task_reg, out_task_next;
    logic                    out_blocked_reg, out_blocked_next;
    logic                    out_idle_reg, out_idle_next;
    logic                    out_nofree_reg, out_nofree_next;

    logic [ID_W-1:0]         link_raddr, link_rdata;
    link_wr_t                link_wr;
    sem_entry_t              sem_rdata;
    sem_wr_t                 sem_wr;

    logic [ID_W-1:0]         head_cur;
    logic [ID_W-1:0]         free_id;
    logic                    sem_ok;
    logic signed [CNT_W-1:0] cnt_dec, cnt_inc;
    logic                    fin_go;

    function automatic logic id_ok(input logic [ID_W-1:0] id);
        id_ok = (id != ID_NONE) && (id <= ID_MAX);
    endfunction

    stq_link_mem #(
        .NUM_TASKS (NUM_TASKS)
    ) u_link_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (link_raddr),
        .rdata (link_rdata),
        .wr    (link_wr)
    );

    stq_sem_mem #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_sem_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (req.sem_index),
        .rdata (sem_rdata),
        .wr    (sem_wr)
    );

    // Pick the lowest unused slot
    always_comb
    begin
        free_id = ID_NONE;
        for (int i = NUM_TASKS; i >= 1; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_id = ID_W'(i);
            end
        end
    end

    assign head_cur = (target_reg == Q_WAIT) ? whead_reg : rhead_reg;
    assign sem_ok   = {1'b0, req.sem_index} < SEM_LIM;
    assign cnt_dec  = (sem_rdata.count > CNT_MIN) ? sem_rdata.count - 8'sd1 : sem_rdata.count;
    assign cnt_inc  = (sem_rdata.count < CNT_MAX) ? sem_rdata.count + 8'sd1 : sem_rdata.count;
    assign fin_go   = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.task_out     = out_task_reg;
    assign rsp.blocked      = out_blocked_reg;
    assign rsp.idle         = out_idle_reg;
    assign rsp.no_free_slot = out_nofree_reg;

    // Sequence the action through reads and write-backs of the stores
    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        sem_next         = sem_reg;
        caller_next      = caller_reg;
        target_next      = target_reg;
        phase_next       = phase_reg;
        touch_next       = touch_reg;
        id_next          = id_reg;
        cur_next         = cur_reg;
        step_next        = step_reg;
        pop_next         = pop_reg;
        rhead_next       = rhead_reg;
        cnt_next         = cnt_reg;
        whead_next       = whead_reg;
        slot_used_next   = slot_used_reg;
        res_task_next    = res_task_reg;
        res_blocked_next = res_blocked_reg;
        res_idle_next    = res_idle_reg;
        res_nofree_next  = res_nofree_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_task_next    = out_task_reg;
        out_blocked_next = out_blocked_reg;
        out_idle_next    = out_idle_reg;
        out_nofree_next  = out_nofree_reg;
        link_raddr       = ID_NONE;
        link_wr          = '0;
        sem_wr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next         = req.action;
                    sem_next         = req.sem_index;
                    caller_next      = req.caller_task;
                    phase_next       = 1'b0;
                    touch_next       = 1'b0;
                    target_next      = Q_READY;
                    res_task_next    = ID_NONE;
                    res_blocked_next = 1'b0;
                    res_idle_next    = 1'b0;
                    res_nofree_next  = 1'b0;
                    case (req.action)
                        ACT_REGISTER:
                        begin
                            if (free_id != ID_NONE)
                            begin
                                // Claim the slot and drop any stale link before the walk
                                slot_used_next[free_id[SLOT_W-1:0]] = 1'b1;
                                link_wr    = '{we: 1'b1, addr: free_id, data: ID_NONE};
                                id_next    = free_id;
                                state_next = S_A_START;
                            end
                            else
                            begin
                                res_nofree_next = 1'b1;
                                state_next      = S_FINISH;
                            end
                        end
                        ACT_START:
                        begin
                            state_next = S_P_START;
                        end
                        ACT_P:
                        begin
                            state_next = (sem_ok && id_ok(req.caller_task)) ? S_SEM : S_FINISH;
                        end
                        default:
                        begin
                            state_next = sem_ok ? S_SEM : S_FINISH;
                        end
                    endcase
                end
            end

            // Update the count; decide whether a queue moves
            S_SEM:
            begin
                whead_next  = sem_rdata.head;
                touch_next  = 1'b1;
                target_next = Q_WAIT;
                if (act_reg == ACT_P)
                begin
                    cnt_next = cnt_dec;
                    id_next  = caller_reg;
                    state_next = (cnt_dec < 0) ? S_A_START : S_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = (cnt_inc <= 0) ? S_P_START : S_FINISH;
                end
            end

            // Append: empty queue takes the id as head, else walk to the tail
            S_A_START:
            begin
                if (!id_ok(head_cur))
                begin
                    if (target_reg == Q_WAIT)
                    begin
                        whead_next = id_reg;
                    end
                    else
                    begin
                        rhead_next = id_reg;
                    end
                    state_next = S_A_CLR;
                end
                else
                begin
                    cur_next   = head_cur;
                    step_next  = '0;
                    link_raddr = head_cur;
                    state_next = S_A_WAIT;
                end
            end

            S_A_WAIT:
            begin
                if (!id_ok(link_rdata))
                begin
                    link_wr    = '{we: 1'b1, addr: cur_reg, data: id_reg};
                    state_next = S_A_CLR;
                end
                else if (step_reg == STEP_LAST)
                begin
                    link_wr    = '{we: 1'b1, addr: link_rdata, data: id_reg};
                    state_next = S_A_CLR;
                end
                else
                begin
                    cur_next   = link_rdata;
                    step_next  = step_reg + 1'b1;
                    link_raddr = link_rdata;
                end
            end

            // Clear the appended task's link
            S_A_CLR:
            begin
                link_wr    = '{we: 1'b1, addr: id_reg, data: ID_NONE};
                state_next = S_NEXT;
            end

            // Pop: take the head, fetch its link
            S_P_START:
            begin
                if (!id_ok(head_cur))
                begin
                    if (target_reg == Q_WAIT)
                    begin
                        whead_next = ID_NONE;
                    end
                    else
                    begin
                        rhead_next = ID_NONE;
                    end
                    pop_next   = ID_NONE;
                    state_next = S_NEXT;
                end
                else
                begin
                    pop_next   = head_cur;
                    link_raddr = head_cur;
                    state_next = S_P_WAIT;
                end
            end

            S_P_WAIT:
            begin
                if (target_reg == Q_WAIT)
                begin
                    whead_next = link_rdata;
                end
                else
                begin
                    rhead_next = link_rdata;
                end
                link_wr    = '{we: 1'b1, addr: pop_reg, data: ID_NONE};
                state_next = S_NEXT;
            end

            // Chain the second queue step or settle the result
            S_NEXT:
            begin
                state_next = S_FINISH;
                case (act_reg)
                    ACT_REGISTER:
                    begin
                        res_task_next = id_reg;
                    end
                    ACT_START:
                    begin
                        res_task_next = pop_reg;
                        res_idle_next = (pop_reg == ID_NONE);
                    end
                    ACT_P:
                    begin
                        if (!phase_reg)
                        begin
                            phase_next  = 1'b1;
                            target_next = Q_READY;
                            state_next  = S_P_START;
                        end
                        else
                        begin
                            res_task_next    = pop_reg;
                            res_blocked_next = 1'b1;
                            res_idle_next    = (pop_reg == ID_NONE);
                        end
                    end
                    default:
                    begin
                        if (!phase_reg && (pop_reg != ID_NONE))
                        begin
                            phase_next  = 1'b1;
                            target_next = Q_READY;
                            id_next     = pop_reg;
                            state_next  = S_A_START;
                        end
                    end
                endcase
            end

            // Write back the semaphore and hand over the result
            S_FINISH:
            begin
                sem_wr.we         = touch_reg;
                sem_wr.addr       = sem_reg;
                sem_wr.data.count = cnt_reg;
                sem_wr.data.head  = whead_reg;
                if (fin_go)
                begin
                    out_valid_next   = 1'b1;
                    out_task_next    = res_task_reg;
                    out_blocked_next = res_blocked_reg;
                    out_idle_next    = res_idle_reg;
                    out_nofree_next  = res_nofree_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            act_reg         <= ACT_REGISTER;
            sem_reg         <= '0;
            caller_reg      <= ID_NONE;
            target_reg      <= Q_READY;
            phase_reg       <= 1'b0;
            touch_reg       <= 1'b0;
            id_reg          <= ID_NONE;
            cur_reg         <= ID_NONE;
            step_reg        <= '0;
            pop_reg         <= ID_NONE;
            rhead_reg       <= ID_NONE;
            cnt_reg         <= CNT_RESET;
            whead_reg       <= ID_NONE;
            slot_used_reg   <= '0;
            res_task_reg    <= ID_NONE;
            res_blocked_reg <= 1'b0;
            res_idle_reg    <= 1'b0;
            res_nofree_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_task_reg    <= ID_NONE;
            out_blocked_reg <= 1'b0;
            out_idle_reg    <= 1'b0;
            out_nofree_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            act_reg         <= act_next;
            sem_reg         <= sem_next;
            caller_reg      <= caller_next;
            target_reg      <= target_next;
            phase_reg       <= phase_next;
            touch_reg       <= touch_next;
            id_reg          <= id_next;
            cur_reg         <= cur_next;
            step_reg        <= step_next;
            pop_reg         <= pop_next;
            rhead_reg       <= rhead_next;
            cnt_reg         <= cnt_next;
            whead_reg       <= whead_next;
            slot_used_reg   <= slot_used_next;
            res_task_reg    <= res_task_next;
            res_blocked_reg <= res_blocked_next;
            res_idle_reg    <= res_idle_next;
            res_nofree_reg  <= res_nofree_next;
            out_valid_reg   <= out_valid_next;
            out_task_reg    <= out_task_next;
            out_blocked_reg <= out_blocked_next;
            out_idle_reg    <= out_idle_next;
            out_nofree_reg  <= out_nofree_next;
        end
    end

    // Ready head is always none or a valid slot id
    assert property (@(posedge clk) disable iff (!rst_n)
        rhead_reg <= ID_MAX)
    else $error("ready head out of range");

    // A result handed over in the final state is presented next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && fin_go) |=> (rsp.valid && state_reg == S_IDLE))
    else $error("result not presented after finish");

    // A full slot table never yields an id, and never blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.no_free_slot) |-> (rsp.task_out == ID_NONE && !rsp.blocked))
    else $error("no-free-slot result carries an id");

    // Idle means no task was handed out
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.idle) |-> (rsp.task_out == ID_NONE))
    else $error("idle result carries a task");

    // A link read is only ever made on a valid slot id while walking or popping
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_WAIT || state_reg == S_P_WAIT) |-> $past(id_ok(link_raddr)))
    else $error("link read at an invalid slot");

endmodule

`default_nettype wire
